// ----- sv/dsf_pkg.sv -----
package dsf_pkg;

  localparam int unsigned MAX_KEPT_DEFAULT = 64;

  localparam int unsigned ID_W    = 32;
  localparam int unsigned EXON_W  = 10;
  localparam int unsigned COORD_W = 32;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned SIM_W   = 7;
  localparam int unsigned LIMIT_W = 16;

  localparam logic [POS_W-1:0]   POS_MAX          = '1;
  localparam logic [SIM_W-1:0]   SIM_MAX          = '1;
  localparam logic [LIMIT_W-1:0] NEAR_LIMIT_RESET = LIMIT_W'(10);

  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 2;

  // controller -> datapath
  typedef struct packed {
    logic load;    // accept input beat
    logic scan;    // walk the kept table
    logic commit;  // store kept record (if room), load result register
  } dsf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dsf_stat_t;

endpackage

// ----- sv/duplicate_span_filter.sv -----
// Duplicate span filter.
// Input channel (in_valid/in_stall) takes one alignment record per beat:
// query_id, target_id, exon_count, span_start, span_end. A change of
// query_id opens a new group and empties the kept table.
// Output channel (out_valid/out_stall) gives exactly one result beat per
// record: keep, position, duplicate_of, similar_count, first_similar,
// not_stored, group_start.
// near_limit sits at APB address 0 (reset value 10); write it only while
// the block is idle.
// Timing: one record at a time. The scan reads one table entry per cycle
// over the records kept so far in its group (at most MAX_KEPT); an exact
// match ends the scan early. The input reopens once the result is written.
// The result register lets the next record be accepted and scanned while a
// result waits; a stalled receiver holds the block only when a second result
// is ready to be written.
// Reset (synchronous) empties the table, closes the group and clears
// out_valid; the table memory itself needs no clearing pass.
module duplicate_span_filter #(
  parameter int unsigned MAX_KEPT = dsf_pkg::MAX_KEPT_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dsf_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [dsf_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [dsf_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [dsf_pkg::ID_W-1:0]        query_id,
  input  logic [dsf_pkg::ID_W-1:0]        target_id,
  input  logic [dsf_pkg::EXON_W-1:0]      exon_count,
  input  logic [dsf_pkg::COORD_W-1:0]     span_start,
  input  logic [dsf_pkg::COORD_W-1:0]     span_end,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            keep,
  output logic [dsf_pkg::POS_W-1:0]       position,
  output logic [dsf_pkg::POS_W-1:0]       duplicate_of,
  output logic [dsf_pkg::SIM_W-1:0]       similar_count,
  output logic [dsf_pkg::POS_W-1:0]       first_similar,
  output logic                            not_stored,
  output logic                            group_start
);

  logic [dsf_pkg::LIMIT_W-1:0] near_limit;
  dsf_pkg::dsf_cmd_t           cmd;
  dsf_pkg::dsf_stat_t          stat;
  logic                        unused_addr;

  // single register: every word address decodes to near_limit
  assign pready      = 1'b1;
  assign prdata      = dsf_pkg::APB_DATA_W'(near_limit);
  assign unused_addr = ^paddr;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_limit <= dsf_pkg::NEAR_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && (unused_addr || !unused_addr)) begin
      near_limit <= pwdata[dsf_pkg::LIMIT_W-1:0];
    end
  end

  dsf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  dsf_datapath #(
    .MAX_KEPT (MAX_KEPT)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .near_limit    (near_limit),
    .query_id      (query_id),
    .target_id     (target_id),
    .exon_count    (exon_count),
    .span_start    (span_start),
    .span_end      (span_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .keep          (keep),
    .position      (position),
    .duplicate_of  (duplicate_of),
    .similar_count (similar_count),
    .first_similar (first_similar),
    .not_stored    (not_stored),
    .group_start   (group_start)
  );

endmodule

// ----- sv/dsf_ctrl.sv -----
module dsf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  dsf_pkg::dsf_stat_t stat,
  output dsf_pkg::dsf_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- sv/dsf_datapath.sv -----
module dsf_datapath #(
  parameter int unsigned MAX_KEPT = dsf_pkg::MAX_KEPT_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  dsf_pkg::dsf_cmd_t            cmd,
  output dsf_pkg::dsf_stat_t           stat,
  input  logic [dsf_pkg::LIMIT_W-1:0]  near_limit,
  input  logic [dsf_pkg::ID_W-1:0]     query_id,
  input  logic [dsf_pkg::ID_W-1:0]     target_id,
  input  logic [dsf_pkg::EXON_W-1:0]   exon_count,
  input  logic [dsf_pkg::COORD_W-1:0]  span_start,
  input  logic [dsf_pkg::COORD_W-1:0]  span_end,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         keep,
  output logic [dsf_pkg::POS_W-1:0]    position,
  output logic [dsf_pkg::POS_W-1:0]    duplicate_of,
  output logic [dsf_pkg::SIM_W-1:0]    similar_count,
  output logic [dsf_pkg::POS_W-1:0]    first_similar,
  output logic                         not_stored,
  output logic                         group_start
);

  localparam int unsigned AW = $clog2(MAX_KEPT);
  localparam int unsigned KW = $clog2(MAX_KEPT + 1);
  localparam logic [KW-1:0] KEPT_FULL = KW'(MAX_KEPT);

  typedef struct packed {
    logic [dsf_pkg::ID_W-1:0]    target;
    logic [dsf_pkg::EXON_W-1:0]  exons;
    logic [dsf_pkg::COORD_W-1:0] start;
    logic [dsf_pkg::COORD_W-1:0] stop;
    logic [dsf_pkg::POS_W-1:0]   pos;
  } entry_t;

  entry_t mem [MAX_KEPT];
  entry_t rd_data;
  entry_t cur;

  logic                        group_open;
  logic [dsf_pkg::ID_W-1:0]    current_query;
  logic [dsf_pkg::POS_W-1:0]   group_counter;
  logic [KW-1:0]               kept_total;
  logic [KW-1:0]               rd_idx;
  logic                        cmp_valid;
  logic                        opened;
  logic                        keep_r;
  logic [dsf_pkg::POS_W-1:0]   dup_r;
  logic [dsf_pkg::SIM_W-1:0]   nsim_r;
  logic [dsf_pkg::POS_W-1:0]   fsim_r;

  logic                        new_group;
  logic [dsf_pkg::POS_W-1:0]   pos_now;
  logic                        rd_more;
  logic                        key_eq;
  logic [dsf_pkg::COORD_W-1:0] sd;
  logic [dsf_pkg::COORD_W-1:0] ed;
  logic [dsf_pkg::COORD_W-1:0] limit_ext;
  logic                        table_room;

  assign new_group  = !group_open || (query_id != current_query);
  assign pos_now    = new_group ? '0 : group_counter;
  assign rd_more    = (rd_idx < kept_total) && keep_r;
  assign key_eq     = (rd_data.target == cur.target) && (rd_data.exons == cur.exons);
  assign sd         = (rd_data.start < cur.start) ? (cur.start - rd_data.start)
                                                  : (rd_data.start - cur.start);
  assign ed         = (rd_data.stop < cur.stop) ? (cur.stop - rd_data.stop)
                                                : (rd_data.stop - cur.stop);
  assign limit_ext  = dsf_pkg::COORD_W'(near_limit);
  assign table_room = kept_total < KEPT_FULL;

  assign stat.scan_done = !keep_r || (!rd_more && !cmp_valid);
  assign stat.out_free  = !out_valid || !out_stall;

  // kept table
  always_ff @(posedge clk) begin
    if (cmd.scan && rd_more) begin
      rd_data <= mem[rd_idx[AW-1:0]];
    end
    if (cmd.commit && keep_r && table_room) begin
      mem[kept_total[AW-1:0]] <= cur;
    end
  end

  // current record
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur.target <= target_id;
      cur.exons  <= exon_count;
      cur.start  <= span_start;
      cur.stop   <= span_end;
      cur.pos    <= pos_now;
      opened     <= new_group;
    end
  end

  // group and scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      group_open    <= 1'b0;
      current_query <= '0;
      group_counter <= '0;
      kept_total    <= '0;
      rd_idx        <= '0;
      cmp_valid     <= 1'b0;
      keep_r        <= 1'b1;
      dup_r         <= '0;
      nsim_r        <= '0;
      fsim_r        <= '0;
    end else begin
      cmp_valid <= 1'b0;
      if (cmd.load) begin
        group_open    <= 1'b1;
        current_query <= query_id;
        group_counter <= (pos_now == dsf_pkg::POS_MAX) ? pos_now : pos_now + 1'b1;
        if (new_group) begin
          kept_total <= '0;
        end
        rd_idx <= '0;
        keep_r <= 1'b1;
        dup_r  <= '0;
        nsim_r <= '0;
        fsim_r <= '0;
      end
      if (cmd.scan && rd_more) begin
        rd_idx    <= rd_idx + 1'b1;
        cmp_valid <= 1'b1;
      end
      if (cmp_valid && keep_r && key_eq) begin
        if ((sd == '0) && (ed == '0)) begin
          keep_r <= 1'b0;
          dup_r  <= rd_data.pos;
        end else if ((sd < limit_ext) && (ed < limit_ext)) begin
          if (nsim_r == '0) begin
            fsim_r <= rd_data.pos;
          end
          if (nsim_r != dsf_pkg::SIM_MAX) begin
            nsim_r <= nsim_r + 1'b1;
          end
        end
      end
      if (cmd.commit && keep_r && table_room) begin
        kept_total <= kept_total + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      keep          <= keep_r;
      position      <= cur.pos;
      duplicate_of  <= dup_r;
      similar_count <= nsim_r;
      first_similar <= fsim_r;
      not_stored    <= keep_r && !table_room;
      group_start   <= opened;
    end
  end

endmodule

// ----- bench/duplicate_span_filter_tb.sv -----
module duplicate_span_filter_tb;

  localparam int unsigned TABLE_DEPTH = dsf_pkg::MAX_KEPT_DEFAULT;
  localparam logic [dsf_pkg::APB_ADDR_W-1:0] NEAR_LIMIT_ADDR = '0;

  typedef struct packed {
    logic [dsf_pkg::ID_W-1:0]    qid;
    logic [dsf_pkg::ID_W-1:0]    tid;
    logic [dsf_pkg::EXON_W-1:0]  exons;
    logic [dsf_pkg::COORD_W-1:0] start_pos;
    logic [dsf_pkg::COORD_W-1:0] end_pos;
  } span_rec_t;

  typedef struct packed {
    logic                      kept;
    logic [dsf_pkg::POS_W-1:0] pos;
    logic [dsf_pkg::POS_W-1:0] dup_of;
    logic [dsf_pkg::SIM_W-1:0] sim_count;
    logic [dsf_pkg::POS_W-1:0] first_sim;
    logic                      not_stored;
    logic                      grp_start;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [dsf_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [dsf_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [dsf_pkg::APB_DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [dsf_pkg::ID_W-1:0] query_id = '0;
  logic [dsf_pkg::ID_W-1:0] target_id = '0;
  logic [dsf_pkg::EXON_W-1:0] exon_count = '0;
  logic [dsf_pkg::COORD_W-1:0] span_start = '0;
  logic [dsf_pkg::COORD_W-1:0] span_end = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic keep;
  logic [dsf_pkg::POS_W-1:0] position;
  logic [dsf_pkg::POS_W-1:0] duplicate_of;
  logic [dsf_pkg::SIM_W-1:0] similar_count;
  logic [dsf_pkg::POS_W-1:0] first_similar;
  logic not_stored;
  logic group_start;

  duplicate_span_filter dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .query_id(query_id), .target_id(target_id), .exon_count(exon_count),
    .span_start(span_start), .span_end(span_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .keep(keep), .position(position), .duplicate_of(duplicate_of),
    .similar_count(similar_count), .first_similar(first_similar),
    .not_stored(not_stored), .group_start(group_start)
  );

  // kept-table model
  logic [dsf_pkg::ID_W-1:0]    tbl_target[TABLE_DEPTH];
  logic [dsf_pkg::EXON_W-1:0]  tbl_exons[TABLE_DEPTH];
  logic [dsf_pkg::COORD_W-1:0] tbl_start[TABLE_DEPTH];
  logic [dsf_pkg::COORD_W-1:0] tbl_end[TABLE_DEPTH];
  logic [dsf_pkg::POS_W-1:0]   tbl_pos[TABLE_DEPTH];
  int unsigned                 tbl_count = 0;
  logic [dsf_pkg::POS_W-1:0]   grp_next = '0;
  logic [dsf_pkg::ID_W-1:0]    cur_query = '0;
  logic                        grp_open = 1'b0;
  logic [dsf_pkg::LIMIT_W-1:0] near_limit_model = dsf_pkg::NEAR_LIMIT_RESET;

  verdict_t pending_verdicts[$];
  int mismatches = 0;
  int burst_left = 0;
  int gap_max = 0;
  int stall_pct = 0;
  int hold_off_len = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [dsf_pkg::COORD_W-1:0] span_gap(
      logic [dsf_pkg::COORD_W-1:0] a, logic [dsf_pkg::COORD_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic verdict_t screen_record(span_rec_t r);
    verdict_t v;
    logic [dsf_pkg::COORD_W-1:0] sd, ed;
    int unsigned i;
    v = '0;
    v.kept = 1'b1;
    if (!grp_open || r.qid != cur_query) begin
      v.grp_start = 1'b1;
      grp_open = 1'b1;
      cur_query = r.qid;
      tbl_count = 0;
      grp_next = '0;
    end
    v.pos = grp_next;
    if (grp_next != dsf_pkg::POS_MAX) grp_next++;
    i = 0;
    while (i < tbl_count && v.kept) begin
      if (tbl_target[i] == r.tid && tbl_exons[i] == r.exons) begin
        sd = span_gap(tbl_start[i], r.start_pos);
        ed = span_gap(tbl_end[i], r.end_pos);
        if (sd == 0 && ed == 0) begin
          v.kept = 1'b0;
          v.dup_of = tbl_pos[i];
        end else if (sd < near_limit_model && ed < near_limit_model) begin
          if (v.sim_count == 0) v.first_sim = tbl_pos[i];
          if (v.sim_count != dsf_pkg::SIM_MAX) v.sim_count++;
        end
      end
      i++;
    end
    if (v.kept) begin
      if (tbl_count < TABLE_DEPTH) begin
        tbl_target[tbl_count] = r.tid;
        tbl_exons[tbl_count] = r.exons;
        tbl_start[tbl_count] = r.start_pos;
        tbl_end[tbl_count] = r.end_pos;
        tbl_pos[tbl_count] = v.pos;
        tbl_count++;
      end else begin
        v.not_stored = 1'b1;
      end
    end
    return v;
  endfunction

  function automatic span_rec_t make_rec(logic [dsf_pkg::ID_W-1:0] q,
                                         logic [dsf_pkg::ID_W-1:0] t,
                                         logic [dsf_pkg::EXON_W-1:0] e,
                                         logic [dsf_pkg::COORD_W-1:0] s,
                                         logic [dsf_pkg::COORD_W-1:0] f);
    span_rec_t r;
    r.qid = q;
    r.tid = t;
    r.exons = e;
    r.start_pos = s;
    r.end_pos = f;
    return r;
  endfunction

  task automatic send_record(input span_rec_t r);
    in_valid <= 1'b1;
    query_id <= r.qid;
    target_id <= r.tid;
    exon_count <= r.exons;
    span_start <= r.start_pos;
    span_end <= r.end_pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_verdicts.push_back(screen_record(r));
    if (gap_max != 0) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic write_near_limit(input logic [dsf_pkg::LIMIT_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= NEAR_LIMIT_ADDR;
    pwdata <= dsf_pkg::APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    near_limit_model = value;
  endtask

  // receiver: stall runs of random length, plus long hold-offs on request
  initial begin : receiver
    int run;
    run = 0;
    forever begin
      @(posedge clk);
      if (hold_off_len != 0) begin
        out_stall <= 1'b1;
        repeat (hold_off_len) @(posedge clk);
        hold_off_len = 0;
        out_stall <= 1'b0;
        run = 0;
      end else if (run != 0) begin
        run--;
      end else begin
        run = $urandom_range(1, 8);
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin : check_result
    verdict_t seen, want;
    if (!rst && out_valid && !out_stall) begin
      seen.kept = keep;
      seen.pos = position;
      seen.dup_of = duplicate_of;
      seen.sim_count = similar_count;
      seen.first_sim = first_similar;
      seen.not_stored = not_stored;
      seen.grp_start = group_start;
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: pos %0d keep %0d", position, keep);
      end else begin
        want = pending_verdicts.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch (want/got): keep %0d/%0d pos %0d/%0d dup %0d/%0d",
                     want.kept, seen.kept, want.pos, seen.pos,
                     want.dup_of, seen.dup_of);
            $display("  sim %0d/%0d first %0d/%0d full %0d/%0d open %0d/%0d",
                     want.sim_count, seen.sim_count,
                     want.first_sim, seen.first_sim,
                     want.not_stored, seen.not_stored,
                     want.grp_start, seen.grp_start);
          end
        end
      end
    end
  end

  task automatic test_directed();
    stall_pct = 20;
    gap_max = 3;
    // query 0 right after reset must still open a group
    send_record(make_rec('0, 5, 1, 100, 200));
    send_record(make_rec('0, 5, 1, 100, 200));
    send_record(make_rec('0, 5, 1, 109, 191));
    send_record(make_rec('0, 5, 1, 110, 200));
    send_record(make_rec('0, 5, 2, 100, 200));
    send_record(make_rec('0, 6, 1, 100, 200));
    send_record(make_rec('0, '0, 1, '0, '0));
    send_record(make_rec('0, '1, 1023, '1, '1));
    send_record(make_rec('0, '1, 1023, '0, '1));
    send_record(make_rec('0, '1, 1023, '1, 32'hFFFF_FFFA));
    send_record(make_rec('0, '0, 1, '0, '0));
    send_record(make_rec('1, 5, 1, 100, 200));
    send_record(make_rec(1, 5, 1, 100, 200));
    send_record(make_rec('1, 5, 1, 100, 200));
    send_record(make_rec('1, 5, 1, 100, 200));
    settle();
    write_near_limit('0);
    send_record(make_rec(7, 9, 3, 1000, 2000));
    send_record(make_rec(7, 9, 3, 1001, 2000));
    send_record(make_rec(7, 9, 3, 1000, 2000));
    settle();
    write_near_limit('1);
    send_record(make_rec(8, 9, 3, '0, '0));
    send_record(make_rec(8, 9, 3, 65534, 65534));
    send_record(make_rec(8, 9, 3, 65535, 1));
    send_record(make_rec(8, 9, 3, '1, '0));
    settle();
  endtask

  task automatic test_full_table();
    stall_pct = 30;
    gap_max = 5;
    for (int i = 0; i < TABLE_DEPTH; i++)
      send_record(make_rec(32'hC0DE_0001, 32'h1234_5678, 7, 1000 + i, 2000 + i));
    // table full: kept, not stored, never compared later
    send_record(make_rec(32'hC0DE_0001, 32'h1234_5678, 7, 5000, 6000));
    send_record(make_rec(32'hC0DE_0001, 32'h1234_5678, 7, 5000, 6000));
    send_record(make_rec(32'hC0DE_0001, 32'h1234_5678, 7, 1000, 2000));
    send_record(make_rec(32'hC0DE_0001, 32'h1234_5678, 7, 1063, 2063));
    send_record(make_rec(32'hC0DE_0001, 32'h8765_4321, 7, 1000, 2000));
    settle();
  endtask

  task automatic test_random();
    span_rec_t history[$];
    span_rec_t r;
    logic [dsf_pkg::ID_W-1:0] grp_query;
    logic [dsf_pkg::ID_W-1:0] tgt_pool[3];
    logic [dsf_pkg::EXON_W-1:0] ex_pool[3];
    int sent, grp_len, pick, lim;
    grp_query = $urandom;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_near_limit(dsf_pkg::NEAR_LIMIT_RESET);
          stall_pct = 0;
          gap_max = 0;
        end
        1: begin
          write_near_limit('0);
          stall_pct = 30;
          gap_max = 6;
          hold_off_len = 600;
        end
        2: begin
          write_near_limit('1);
          stall_pct = 60;
          gap_max = 40;
        end
        3: begin
          write_near_limit(dsf_pkg::LIMIT_W'($urandom_range(1, 400)));
          stall_pct = 15;
          gap_max = 3;
        end
        default: begin
          write_near_limit(dsf_pkg::LIMIT_W'($urandom_range(0, 65535)));
          stall_pct = 40;
          gap_max = 20;
        end
      endcase
      lim = int'(near_limit_model);
      sent = 0;
      while (sent < 372) begin
        pick = $urandom_range(99);
        if (pick < 5) grp_query = '0;
        else if (pick >= 15) grp_query = $urandom;
        history.delete();
        grp_len = ($urandom_range(99) < 12) ? $urandom_range(60, 100)
                                            : $urandom_range(1, 20);
        foreach (tgt_pool[j]) tgt_pool[j] = $urandom;
        ex_pool[0] = dsf_pkg::EXON_W'($urandom_range(1, 1023));
        ex_pool[1] = dsf_pkg::EXON_W'($urandom_range(1, 1023));
        ex_pool[2] = dsf_pkg::EXON_W'($urandom_range(1) ? 1023 : 1);
        for (int k = 0; k < grp_len && sent < 372; k++) begin
          pick = $urandom_range(99);
          if (history.size() != 0 && pick < 25) begin
            r = history[$urandom_range(history.size() - 1)];
          end else if (history.size() != 0 && pick < 65) begin
            r = history[$urandom_range(history.size() - 1)];
            r.start_pos += dsf_pkg::COORD_W'($urandom_range(0, 2 * lim + 2))
                           - dsf_pkg::COORD_W'(lim + 1);
            r.end_pos += dsf_pkg::COORD_W'($urandom_range(0, 2 * lim + 2))
                         - dsf_pkg::COORD_W'(lim + 1);
          end else if (pick < 95) begin
            r.tid = tgt_pool[$urandom_range(2)];
            r.exons = ex_pool[$urandom_range(2)];
            r.start_pos = (pick < 85) ? dsf_pkg::COORD_W'($urandom)
                                      : dsf_pkg::COORD_W'($urandom_range(0, 40)) - 20;
            r.end_pos = (pick < 80) ? r.start_pos + $urandom_range(0, 20000)
                                    : dsf_pkg::COORD_W'($urandom);
          end else begin
            r.tid = $urandom;
            r.exons = dsf_pkg::EXON_W'($urandom_range(1, 1023));
            r.start_pos = $urandom;
            r.end_pos = $urandom;
          end
          r.qid = grp_query;
          send_record(r);
          history.push_back(r);
          sent++;
        end
      end
      // sender waits for every outstanding result before the next phase
      settle();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    write_near_limit('1);
    test_full_table();
    test_random();
    settle();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending_verdicts.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #8000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- duplicate_span_filter.f -----
sv/dsf_pkg.sv
sv/dsf_ctrl.sv
sv/dsf_datapath.sv
sv/duplicate_span_filter.sv
bench/duplicate_span_filter_tb.sv
